// ===== hdl/fbrf_pkg.sv =====
// Shared types, constants and helpers for the framed byte ring FIFO.
package fbrf_pkg;

	localparam int DEPTH = 4096;
	localparam int PTR_W = 12;
	localparam int CAP_W = 13;
	localparam int CNT_W = 3;

	localparam logic [CAP_W-1:0] CAP_MIN = 13'd2;
	localparam logic [CAP_W-1:0] CAP_MAX = 13'd4096;

	// operation kinds
	localparam logic [2:0] KIND_PUSH  = 3'd0;
	localparam logic [2:0] KIND_POP   = 3'd1;
	localparam logic [2:0] KIND_WHDR  = 3'd2;
	localparam logic [2:0] KIND_RHDR  = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	// result status codes
	localparam logic [1:0] STS_OK         = 2'd0;
	localparam logic [1:0] STS_NO_ROOM    = 2'd1;
	localparam logic [1:0] STS_TOO_LONG   = 2'd2;
	localparam logic [1:0] STS_INCOMPLETE = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic       load_item;
		logic       ram_wr;
		logic       hdr_byte;
		logic [1:0] byte_idx;
		logic       adv_wp;
		logic       adv_scan;
		logic       pop_commit;
		logic       shift_len;
		logic       hdr_commit;
		logic       clear_ptrs;
		logic       set_status;
		logic [1:0] status_code;
		logic       load_out;
	} fbrf_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] kind;
		logic       full;
		logic       empty;
		logic       occ_ge4;
		logic       hdr_room;
		logic       len_over;
		logic       len_short;
		logic       out_free;
	} fbrf_sts_t;

	// next slot in the ring, wrapping at the capacity in use
	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] inc;
		inc = {1'b0, p} + 13'd1;
		return (inc >= cap) ? '0 : inc[PTR_W-1:0];
	endfunction

endpackage

// ===== hdl/fbrf_ram.sv =====
// Generic single-port RAM with registered read data.
module fbrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/fbrf_dp.sv =====
// Datapath: pointers, occupancy, byte store, header assembly and result register.
module fbrf_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [2:0]                in_kind,
	input  logic [7:0]                in_byte,
	input  logic [11:0]               in_arg,
	input  logic                      cfg_wr_en,
	input  logic [12:0]               cfg_wr_data,
	input  fbrf_pkg::fbrf_cmd_t       cmd,
	output fbrf_pkg::fbrf_sts_t       sts,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [63:0]               m_tdata,
	output logic [7:0]                m_tuser
);

	logic [fbrf_pkg::CAP_W-1:0] cap_q;
	logic [fbrf_pkg::PTR_W-1:0] rp_q, wp_q, scan_q, occ_q;
	logic [fbrf_pkg::PTR_W-1:0] free_sp;
	logic [fbrf_pkg::CAP_W-1:0] free_wide;
	logic [2:0]  kind_q;
	logic [7:0]  data_q;
	logic [11:0] arg_q;
	logic [1:0]  status_q;
	logic [7:0]  rbyte_q;
	logic [31:0] flen_q;
	logic [7:0]  wr_byte, rd_byte;
	logic [fbrf_pkg::PTR_W-1:0] ram_addr;
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [1:0]  out_user_q;
	logic [fbrf_pkg::CAP_W-1:0] cfg_cap;

	// free space after what is stored; one slot always stays empty
	assign free_wide = cap_q - 13'd1 - {1'b0, occ_q};
	assign free_sp   = free_wide[fbrf_pkg::PTR_W-1:0];

	always_comb begin
		sts.kind      = kind_q;
		sts.full      = (free_sp == '0);
		sts.empty     = (occ_q == '0);
		sts.occ_ge4   = (occ_q >= 12'd4);
		sts.hdr_room  = ({1'b0, free_sp} >= ({1'b0, arg_q} + 13'd4));
		sts.len_over  = (flen_q > {20'd0, arg_q});
		sts.len_short = ({21'd0, occ_q} < ({1'b0, flen_q} + 33'd4));
		sts.out_free  = !out_valid_q || m_tready;
	end

	// clamp a configured capacity to the supported range
	always_comb begin
		if (cfg_wr_data < fbrf_pkg::CAP_MIN) begin
			cfg_cap = fbrf_pkg::CAP_MIN;
		end else if (cfg_wr_data > fbrf_pkg::CAP_MAX) begin
			cfg_cap = fbrf_pkg::CAP_MAX;
		end else begin
			cfg_cap = cfg_wr_data;
		end
	end

	// header bytes go out most significant first; the top two are always zero
	always_comb begin
		if (cmd.hdr_byte) begin
			case (cmd.byte_idx)
				2'd2:    wr_byte = {4'h0, arg_q[11:8]};
				2'd3:    wr_byte = arg_q[7:0];
				default: wr_byte = 8'h00;
			endcase
		end else begin
			wr_byte = data_q;
		end
	end

	assign ram_addr = cmd.ram_wr ? wp_q : scan_q;

	fbrf_ram #(
		.WIDTH(8),
		.DEPTH(fbrf_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.ram_wr),
		.addr (ram_addr),
		.wdata(wr_byte),
		.rdata(rd_byte)
	);

	// capacity, pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= fbrf_pkg::CAP_MAX;
			rp_q   <= '0;
			wp_q   <= '0;
			scan_q <= '0;
			occ_q  <= '0;
		end else if (cfg_wr_en) begin
			cap_q  <= cfg_cap;
			rp_q   <= '0;
			wp_q   <= '0;
			scan_q <= '0;
			occ_q  <= '0;
		end else begin
			if (cmd.load_item) begin
				scan_q <= rp_q;
			end
			if (cmd.adv_scan) begin
				scan_q <= fbrf_pkg::next_pos(scan_q, cap_q);
			end
			if (cmd.adv_wp) begin
				wp_q  <= fbrf_pkg::next_pos(wp_q, cap_q);
				occ_q <= occ_q + 12'd1;
			end
			if (cmd.pop_commit) begin
				rp_q  <= fbrf_pkg::next_pos(rp_q, cap_q);
				occ_q <= occ_q - 12'd1;
			end
			if (cmd.hdr_commit) begin
				rp_q  <= scan_q;
				occ_q <= occ_q - 12'd4;
			end
			if (cmd.clear_ptrs) begin
				rp_q  <= '0;
				wp_q  <= '0;
				occ_q <= '0;
			end
		end
	end

	// item and result work registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q   <= in_kind;
			data_q   <= in_byte;
			arg_q    <= in_arg;
			status_q <= fbrf_pkg::STS_OK;
			rbyte_q  <= 8'h00;
			flen_q   <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.pop_commit) begin
				rbyte_q <= rd_byte;
			end
			if (cmd.shift_len) begin
				flen_q <= {flen_q[23:0], rd_byte};
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {free_sp, occ_q, flen_q, rbyte_q};
			out_user_q <= status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {6'd0, out_user_q};

endmodule

// ===== hdl/fbrf_ctrl.sv =====
// Controller: sequences each operation over the single-port byte store.
module fbrf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  fbrf_pkg::fbrf_sts_t sts,
	output fbrf_pkg::fbrf_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_POP  = 3'd2;
	localparam logic [2:0] ST_WHDR = 3'd3;
	localparam logic [2:0] ST_RHDR = 3'd4;
	localparam logic [2:0] ST_RCHK = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q, state_nxt;
	logic [fbrf_pkg::CNT_W-1:0] cnt_q, cnt_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		cnt_nxt   = cnt_q;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_EXEC;
				end
			end
			// decide on the operation once its checks are known
			ST_EXEC: begin
				cnt_nxt   = '0;
				state_nxt = ST_DONE;
				unique case (sts.kind)
					fbrf_pkg::KIND_PUSH: begin
						if (sts.full) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = fbrf_pkg::STS_NO_ROOM;
						end else begin
							cmd.ram_wr = 1'b1;
							cmd.adv_wp = 1'b1;
						end
					end
					fbrf_pkg::KIND_POP: begin
						if (sts.empty) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = fbrf_pkg::STS_NO_ROOM;
						end else begin
							state_nxt = ST_POP;
						end
					end
					fbrf_pkg::KIND_WHDR: begin
						if (!sts.hdr_room) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = fbrf_pkg::STS_NO_ROOM;
						end else begin
							state_nxt = ST_WHDR;
						end
					end
					fbrf_pkg::KIND_RHDR: begin
						if (!sts.occ_ge4) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = fbrf_pkg::STS_NO_ROOM;
						end else begin
							state_nxt = ST_RHDR;
						end
					end
					fbrf_pkg::KIND_CLEAR: begin
						cmd.clear_ptrs = 1'b1;
					end
					default: begin
					end
				endcase
			end
			// read data for the front byte is back from the store
			ST_POP: begin
				cmd.pop_commit = 1'b1;
				state_nxt      = ST_DONE;
			end
			// store the four header bytes, one a cycle
			ST_WHDR: begin
				cmd.ram_wr   = 1'b1;
				cmd.hdr_byte = 1'b1;
				cmd.byte_idx = cnt_q[1:0];
				cmd.adv_wp   = 1'b1;
				cnt_nxt      = cnt_q + 3'd1;
				if (cnt_q == 3'd3) begin
					state_nxt = ST_DONE;
				end
			end
			// issue four reads, collecting each byte in the cycle after its read
			ST_RHDR: begin
				if (cnt_q != 3'd4) begin
					cmd.adv_scan = 1'b1;
				end
				if (cnt_q != 3'd0) begin
					cmd.shift_len = 1'b1;
				end
				cnt_nxt = cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					state_nxt = ST_RCHK;
				end
			end
			ST_RCHK: begin
				state_nxt = ST_DONE;
				if (sts.len_over) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = fbrf_pkg::STS_TOO_LONG;
				end else if (sts.len_short) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = fbrf_pkg::STS_INCOMPLETE;
				end else begin
					cmd.hdr_commit = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

endmodule

// ===== hdl/framed_byte_ring_fifo_unit.sv =====
// Top level: byte ring FIFO holding length-prefixed frames.
// One operation at a time. Push, clear, unused kinds and operations refused at the first check
// go straight to the result; pop first reads the front byte, and header operations touch four
// bytes in turn in the single-port byte store, read header then checking the length it found.
// The next beat can be taken in the cycle after the result is loaded, which waits for a free output.
// Reset empties the ring and sets capacity to 4096; store contents stay undefined.
module framed_byte_ring_fifo_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,      // data_byte[7:0], length_or_limit[19:8], zero pad
	input  logic [7:0]  s_tuser,      // kind[2:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,      // read_byte, frame_length, occupancy, free_space
	output logic [7:0]  m_tuser,      // status[1:0], zero pad
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data   // capacity_in_use
);

	fbrf_pkg::fbrf_cmd_t cmd;
	fbrf_pkg::fbrf_sts_t sts;

	fbrf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fbrf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_kind    (s_tuser[2:0]),
		.in_byte    (s_tdata[7:0]),
		.in_arg     (s_tdata[19:8]),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.sts        (sts),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== hdl/fbrf_checker.sv =====
// Port-level checks for the framed byte ring FIFO, bound to the top level.
module fbrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [7:0]  m_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one operation at a time: no second beat right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an operation is in progress");

	// occupancy plus free space never exceeds the largest ring
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[51:40]} + {1'b0, m_tdata[63:52]}) <= 13'd4095)
		else $error("occupancy and free space inconsistent");

	// a failed operation returns no byte
	a_fail_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != fbrf_pkg::STS_OK) |-> m_tdata[7:0] == 8'h00)
		else $error("byte returned with failing status");

	// an over-limit frame always carries a nonzero length
	a_over_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == fbrf_pkg::STS_TOO_LONG) |-> m_tdata[39:8] != 32'd0)
		else $error("over-limit status with zero length");

endmodule

bind framed_byte_ring_fifo_unit fbrf_checker u_fbrf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the framed byte ring FIFO: corners, back-pressure, framed traffic.
module tb_top;

	// kinds the block leaves unused; they must answer ok and change nothing
	localparam logic [2:0] KIND_RSVD_5 = 3'd5;
	localparam logic [2:0] KIND_RSVD_6 = 3'd6;
	localparam logic [2:0] KIND_RSVD_7 = 3'd7;

	// cycles allowed for the block to settle before a capacity write
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  rbyte;
		logic [31:0] flen;
		logic [11:0] occ;
		logic [11:0] freec;
	} ring_reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // data_byte[7:0], length_or_limit[19:8], zero pad
	logic [7:0]  s_tuser = '0;     // kind[2:0], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;          // read_byte, frame_length, occupancy, free_space
	logic [7:0]  m_tuser;          // status[1:0], zero pad
	logic        cfg_wr_en = 1'b0;
	logic [12:0] cfg_wr_data = '0;

	// ring contents and pointers as the bench expects them
	logic [7:0]  ring_mem [fbrf_pkg::DEPTH];
	int          rd_at = 0;
	int          wr_at = 0;
	int          cap_now = fbrf_pkg::DEPTH;

	ring_reply_t pending_replies [$];
	int          fail_count = 0;
	int          items_sent = 0;
	int          replies_seen = 0;
	int          cap_settings = 1;
	int          status_seen [4] = '{0, 0, 0, 0};

	// idle controls shared by both sides
	bit          no_idle = 1'b0;
	int          stall_request = 0;
	bit          holding = 1'b0;

	framed_byte_ring_fifo_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---- predictor ----
	function automatic int step_pos(input int p);
		return (p + 1 >= cap_now) ? 0 : p + 1;
	endfunction

	function automatic int fill_level();
		return (wr_at >= rd_at) ? wr_at - rd_at : wr_at + cap_now - rd_at;
	endfunction

	function automatic void store_byte(input logic [7:0] v);
		ring_mem[wr_at] = v;
		wr_at = step_pos(wr_at);
	endfunction

	function automatic void apply_ring_op(input logic [2:0] kind, input logic [7:0] d,
		input logic [11:0] arg);
		ring_reply_t r;
		int          occ;
		int          room;
		int          p;
		logic [31:0] len;
		r = '0;
		occ = fill_level();
		room = cap_now - 1 - occ;
		case (kind)
			fbrf_pkg::KIND_PUSH: begin
				if (room == 0)
					r.status = fbrf_pkg::STS_NO_ROOM;
				else
					store_byte(d);
			end
			fbrf_pkg::KIND_POP: begin
				if (occ == 0) begin
					r.status = fbrf_pkg::STS_NO_ROOM;
				end else begin
					r.rbyte = ring_mem[rd_at];
					rd_at = step_pos(rd_at);
				end
			end
			fbrf_pkg::KIND_WHDR: begin
				// header is the 32-bit length, most significant byte first
				if (room < 4 + int'(arg)) begin
					r.status = fbrf_pkg::STS_NO_ROOM;
				end else begin
					store_byte(8'h00);
					store_byte(8'h00);
					store_byte({4'h0, arg[11:8]});
					store_byte(arg[7:0]);
				end
			end
			fbrf_pkg::KIND_RHDR: begin
				if (occ < 4) begin
					r.status = fbrf_pkg::STS_NO_ROOM;
				end else begin
					p = rd_at;
					len = '0;
					repeat (4) begin
						len = {len[23:0], ring_mem[p]};
						p = step_pos(p);
					end
					r.flen = len;
					if (len > {20'h0, arg})
						r.status = fbrf_pkg::STS_TOO_LONG;
					else if (longint'(occ) < 64'd4 + longint'(len))
						r.status = fbrf_pkg::STS_INCOMPLETE;
					else
						rd_at = p;
				end
			end
			fbrf_pkg::KIND_CLEAR: begin
				rd_at = 0;
				wr_at = 0;
			end
			default: ;
		endcase
		occ = fill_level();
		r.occ = 12'(occ);
		r.freec = 12'(cap_now - 1 - occ);
		pending_replies.push_back(r);
	endfunction

	// ---- driving ----
	// offer one operation beat and record its prediction once accepted
	task automatic send_op(input logic [2:0] kind, input logic [7:0] d, input logic [11:0] arg);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'h0, arg, d};
		s_tuser  <= {5'h0, kind};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		apply_ring_op(kind, d, arg);
		items_sent++;
	endtask

	// stop offering, collect every result, then let the block settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [12:0] v);
		logic [12:0] c;
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		c = v;
		if (c < fbrf_pkg::CAP_MIN)
			c = fbrf_pkg::CAP_MIN;
		if (c > fbrf_pkg::CAP_MAX)
			c = fbrf_pkg::CAP_MAX;
		cap_now = int'(c);
		rd_at = 0;
		wr_at = 0;
		cap_settings++;
	endtask

	// result side: ready in random runs, with long holds on request
	initial begin : reply_sink
		int run;
		int gap;
		forever begin
			if (stall_request > 0) begin
				gap = stall_request;
				stall_request = 0;
				holding = 1'b1;
				m_tready <= 1'b0;
				for (int i = 0; i < gap; i++)
					@(posedge clk);
				holding = 1'b0;
			end else begin
				m_tready <= 1'b1;
				run = $urandom_range(1, 12);
				repeat (run) @(posedge clk);
				gap = idle_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// ---- checking: each result beat against the oldest prediction ----
	always @(posedge clk) begin : reply_check
		ring_reply_t got;
		ring_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser[1:0];
			got.rbyte  = m_tdata[7:0];
			got.flen   = m_tdata[39:8];
			got.occ    = m_tdata[51:40];
			got.freec  = m_tdata[63:52];
			replies_seen++;
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result beat: sts=%0d byte=%02h len=%08h occ=%0d free=%0d",
						got.status, got.rbyte, got.flen, got.occ, got.freec);
			end else begin
				want = pending_replies.pop_front();
				status_seen[want.status]++;
				if (got.status !== want.status || got.rbyte !== want.rbyte ||
					got.flen !== want.flen || got.occ !== want.occ ||
					got.freec !== want.freec) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch at result %0d: expected sts=%0d byte=%02h len=%08h %s",
							replies_seen, want.status, want.rbyte, want.flen,
							$sformatf("occ=%0d free=%0d", want.occ, want.freec));
						$display("    got sts=%0d byte=%02h len=%08h occ=%0d free=%0d",
							got.status, got.rbyte, got.flen, got.occ, got.freec);
					end
				end
			end
		end
	end

	// ---- tests ----
	// empty ring at reset capacity: rejects, unused kinds, header limits
	task automatic test_reset_state();
		send_op(fbrf_pkg::KIND_POP, 8'h00, 12'h000);
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'hFFF);
		send_op(KIND_RSVD_5, 8'hFF, 12'hFFF);
		send_op(KIND_RSVD_6, 8'h5A, 12'h0A5);
		send_op(KIND_RSVD_7, 8'hA5, 12'hF5A);
		send_op(fbrf_pkg::KIND_PUSH, 8'h00, 12'h000);
		send_op(fbrf_pkg::KIND_PUSH, 8'hFF, 12'hFFF);
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'hFFF);      // fewer than four bytes
		send_op(fbrf_pkg::KIND_POP, 8'h00, 12'h000);
		send_op(fbrf_pkg::KIND_POP, 8'h00, 12'h000);
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd4095);     // no room for header plus payload
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd4092);
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd4091);     // fits exactly
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'd4095);     // payload missing
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'd4090);     // over the limit
		send_op(fbrf_pkg::KIND_CLEAR, 8'h00, 12'h000);
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd0);
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'd0);        // zero limit takes an empty frame
		repeat (4) send_op(fbrf_pkg::KIND_PUSH, 8'hFF, 12'h000);
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'd4095);     // decoded length all ones
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'd0);
		send_op(fbrf_pkg::KIND_CLEAR, 8'h00, 12'h000);
	endtask

	// clamped and tiny capacities, wrap of a header around the ring end
	task automatic test_capacity_extremes();
		set_capacity(13'd0);
		send_op(fbrf_pkg::KIND_PUSH, 8'hAA, 12'h000);
		send_op(fbrf_pkg::KIND_PUSH, 8'h55, 12'h000);     // single slot already used
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd0);
		send_op(fbrf_pkg::KIND_POP, 8'h00, 12'h000);
		send_op(fbrf_pkg::KIND_POP, 8'h00, 12'h000);
		set_capacity(13'd5);
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd0);
		send_op(fbrf_pkg::KIND_PUSH, 8'h11, 12'h000);
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'd0);
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd0);       // wraps past the last slot
		send_op(fbrf_pkg::KIND_RHDR, 8'h00, 12'd0);
		set_capacity(13'h1FFF);
		send_op(fbrf_pkg::KIND_WHDR, 8'h00, 12'd4091);
		set_capacity(13'd1);
		set_capacity(13'd4097);
	endtask

	// result side held off long enough that the block stops taking beats
	task automatic test_output_backpressure();
		wait_idle();
		no_idle = 1'b1;
		stall_request = 400;
		while (!holding)
			@(posedge clk);
		repeat (24) send_op(fbrf_pkg::KIND_PUSH, 8'($urandom), 12'($urandom));
		repeat (24) send_op(fbrf_pkg::KIND_POP, 8'h00, 12'h000);
		no_idle = 1'b0;
	endtask

	// mostly whole frames with random payloads, plus broken frames and noise
	task automatic test_framed_traffic();
		logic [12:0] cap_v;
		int          start;
		int          room;
		int          len;
		int          part;
		int          lim;
		int          pops;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: cap_v = 13'd6;
				1: cap_v = 13'd4096;
				2: cap_v = 13'($urandom_range(2, 12));
				3: cap_v = 13'd64;
				default: cap_v = 13'($urandom_range(5, 300));
			endcase
			set_capacity(cap_v);
			no_idle = (phase == 3);
			start = items_sent;
			while (items_sent - start < 75) begin
				if ($urandom_range(0, 99) < 75) begin
					room = cap_now - 5 - fill_level();
					if (room < 0)
						room = 0;
					if (room > 48)
						room = 48;
					len = $urandom_range(0, room);
					if ($urandom_range(0, 15) == 0) begin
						// oversized header, usually rejected
						send_op(fbrf_pkg::KIND_WHDR, 8'($urandom),
							12'($urandom_range(room + 1, 4095)));
					end else begin
						send_op(fbrf_pkg::KIND_WHDR, 8'($urandom), 12'(len));
						part = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : len;
						repeat (part)
							send_op(fbrf_pkg::KIND_PUSH, 8'($urandom), 12'($urandom));
						if (part < len) begin
							send_op(fbrf_pkg::KIND_RHDR, 8'($urandom), 12'd4095);
							repeat (len - part)
								send_op(fbrf_pkg::KIND_PUSH, 8'($urandom), 12'($urandom));
						end
						case ($urandom_range(0, 9))
							0: lim = 0;
							1: lim = (len > 0) ? $urandom_range(0, len - 1) : 0;
							default: lim = $urandom_range(len, 4095);
						endcase
						send_op(fbrf_pkg::KIND_RHDR, 8'($urandom), 12'(lim));
						pops = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 2) : len;
						repeat (pops)
							send_op(fbrf_pkg::KIND_POP, 8'($urandom), 12'($urandom));
					end
				end else begin
					send_op(3'($urandom_range(0, 7)), 8'($urandom), 12'($urandom));
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin : stimulus
		wait (arst_n === 1'b1);
		@(posedge clk);
		test_reset_state();
		test_capacity_extremes();
		test_output_backpressure();
		test_framed_traffic();
		wait_idle();
		$display("Ran %0d operations through %0d capacity settings, %0d results checked",
			items_sent, cap_settings, replies_seen);
		$display("Results by status: ok %0d, no room or data %0d, over limit %0d, incomplete %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
